// ----- rtl/dcs_pkg.sv -----
// ----------------------------------------------------------------------------
// dcs_pkg: shared types and constants of the DHCP client sequencer
// Codes for modes, actions, phases and registers; the item and result words.
// ----------------------------------------------------------------------------
package dcs_pkg;

	localparam int unsigned OptionBytesDefault = 312;
	localparam int unsigned OffWidth = 11;
	localparam logic [OffWidth-1:0] OffMax = 11'd2047;

	localparam logic [1:0] MODE_START = 2'd0;
	localparam logic [1:0] MODE_TICK  = 2'd1;
	localparam logic [1:0] MODE_BYTE  = 2'd2;
	localparam logic [1:0] MODE_NONE  = 2'd3;

	localparam logic [2:0] ACT_DISCOVER = 3'd0;
	localparam logic [2:0] ACT_REQUEST  = 3'd1;
	localparam logic [2:0] ACT_SUCCESS  = 3'd2;
	localparam logic [2:0] ACT_FAILURE  = 3'd3;
	localparam logic [2:0] ACT_IGNORED  = 3'd4;

	localparam logic [1:0] PH_IDLE   = 2'd0;
	localparam logic [1:0] PH_WOFFER = 2'd1;
	localparam logic [1:0] PH_WACK   = 2'd2;

	localparam logic [1:0] OPH_CODE = 2'd0;
	localparam logic [1:0] OPH_LEN  = 2'd1;
	localparam logic [1:0] OPH_DATA = 2'd2;

	localparam logic [7:0] OPT_PAD     = 8'h00;
	localparam logic [7:0] OPT_END     = 8'hff;
	localparam logic [7:0] OPT_MASK    = 8'd1;
	localparam logic [7:0] OPT_ROUTER  = 8'd3;
	localparam logic [7:0] OPT_MSGTYPE = 8'd53;
	localparam logic [7:0] MSG_OFFER   = 8'd2;
	localparam logic [7:0] MSG_ACK     = 8'd5;

	localparam logic [0:0] REG_TIMEOUT  = 1'd0;
	localparam logic [0:0] REG_ATTEMPTS = 1'd1;
	localparam logic [15:0] TIMEOUT_RESET  = 16'd1000;
	localparam logic [3:0]  ATTEMPTS_RESET = 4'd4;

	typedef struct packed {
		logic [1:0]  mode;
		logic [7:0]  data_byte;
		logic        last_byte;
		logic [31:0] new_xid;
	} item_t;

	typedef struct packed {
		logic [2:0]  action;
		logic [31:0] xid;
		logic [3:0]  attempt;
		logic [31:0] srv_addr;
		logic [31:0] cli_addr;
		logic [31:0] subnet;
		logic        mask_found;
		logic [31:0] router_addr;
		logic        gateway_found;
	} result_t;

	// classified work from the parser front to the sequencer back
	typedef struct packed {
		logic [1:0]  mode;       // start, tick or end of reply
		logic [31:0] new_xid;
		logic        type_ok;
		logic [7:0]  rtype;
		logic [31:0] yiaddr;
		logic [31:0] siaddr;
		logic [31:0] mask;
		logic        mask_found;
		logic [31:0] gateway;
		logic        gateway_found;
	} cmd_t;

endpackage

// ----- rtl/dcs_item_if.sv -----
// ----------------------------------------------------------------------------
// dcs_item_if: input word channel
// Valid/ready handshake carrying one input item.
// ----------------------------------------------------------------------------
interface dcs_item_if import dcs_pkg::*; ();
	logic  valid;
	logic  ready;
	item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/dcs_result_if.sv -----
// ----------------------------------------------------------------------------
// dcs_result_if: result word channel
// Valid/ready handshake carrying one result item.
// ----------------------------------------------------------------------------
interface dcs_result_if import dcs_pkg::*; ();
	logic    valid;
	logic    ready;
	result_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/dcs_parser.sv -----
// ----------------------------------------------------------------------------
// dcs_parser: front end
// Walks reply bytes (xid check, addresses, option TLVs) and emits commands.
// The xid it checks comes from the back end; an xid byte waits until the
// queue has drained, so every earlier command has reached the back end.
// ----------------------------------------------------------------------------
module dcs_parser import dcs_pkg::*; #(
	parameter int unsigned OPTION_BYTES = OptionBytesDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	dcs_item_if.sink    in_ch,
	input  logic [31:0] cur_xid,
	input  logic        q_busy,
	output logic        cmd_valid,
	output cmd_t        cmd,
	input  logic        cmd_ready
);
	localparam logic [OffWidth-1:0] OptFirst = OffWidth'(240);
	localparam logic [OffWidth-1:0] OptLimit = OffWidth'(236 + OPTION_BYTES);

	logic [OffWidth-1:0] off_q;
	logic [1:0]  oph_q;
	logic [7:0]  ocode_q, oleft_q, oidx_q;
	logic        done_q, mism_q;
	logic [31:0] yi_q, si_q, mask_q, gw_q;
	logic [8:0]  type_q;
	logic        maskf_q, gwf_q;

	logic acc;
	logic xid_hold;
	item_t it;
	logic [7:0] b;
	logic [1:0] sh_idx;
	logic full;

	assign it = in_ch.data;
	assign b = it.data_byte;
	assign xid_hold = (it.mode == MODE_BYTE) && off_q >= 11'd4 && off_q < 11'd8 && q_busy;
	assign in_ch.ready = cmd_ready && !xid_hold;
	assign acc = in_ch.valid && in_ch.ready;

	// next parser values
	logic [OffWidth-1:0] off_n;
	logic [1:0]  oph_n;
	logic [7:0]  ocode_n, oleft_n, oidx_n;
	logic        done_n, mism_n, maskf_n, gwf_n;
	logic [31:0] yi_n, si_n, mask_n, gw_n;
	logic [8:0]  type_n;

	always_comb begin
		off_n = off_q; oph_n = oph_q; ocode_n = ocode_q; oleft_n = oleft_q;
		oidx_n = oidx_q; done_n = done_q; mism_n = mism_q;
		yi_n = yi_q; si_n = si_q; mask_n = mask_q; gw_n = gw_q;
		type_n = type_q; maskf_n = maskf_q; gwf_n = gwf_q;
		sh_idx = off_q[1:0];
		full = ({1'b0, oidx_q} + {1'b0, oleft_q} >= 9'd4) && (oidx_q < 8'd4);
		if (off_q >= 11'd4 && off_q < 11'd8) begin
			if (cur_xid[8*(3-sh_idx) +: 8] != b) mism_n = 1'b1;
		end else if (off_q >= 11'd16 && off_q < 11'd20) begin
			yi_n[8*(3-sh_idx) +: 8] = b;
		end else if (off_q >= 11'd20 && off_q < 11'd24) begin
			si_n[8*(3-sh_idx) +: 8] = b;
		end else if (off_q >= OptFirst && off_q < OptLimit && !done_q) begin
			case (oph_q)
				OPH_CODE: begin
					if (b == OPT_END) done_n = 1'b1;
					else if (b != OPT_PAD) begin
						ocode_n = b;
						oph_n = OPH_LEN;
					end
				end
				OPH_LEN: begin
					oleft_n = b;
					oidx_n = 8'd0;
					oph_n = (b == 8'd0) ? OPH_CODE : OPH_DATA;
				end
				default: begin
					if (ocode_q == OPT_MSGTYPE && oidx_q == 8'd0 && !type_q[8])
						type_n = {1'b1, b};
					if (ocode_q == OPT_MASK && full && !maskf_q) begin
						mask_n[8*(3-oidx_q[1:0]) +: 8] = b;
						if (oidx_q == 8'd3) maskf_n = 1'b1;
					end
					if (ocode_q == OPT_ROUTER && full && !gwf_q) begin
						gw_n[8*(3-oidx_q[1:0]) +: 8] = b;
						if (oidx_q == 8'd3) gwf_n = 1'b1;
					end
					oidx_n = oidx_q + 8'd1;
					oleft_n = oleft_q - 8'd1;
					if (oleft_n == 8'd0) oph_n = OPH_CODE;
				end
			endcase
		end
		if (off_q != OffMax) off_n = off_q + 11'd1;
	end

	logic is_byte, is_end;
	assign is_byte = it.mode == MODE_BYTE;
	assign is_end = is_byte && it.last_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q <= '0; oph_q <= OPH_CODE; ocode_q <= '0; oleft_q <= '0;
			oidx_q <= '0; done_q <= 1'b0; mism_q <= 1'b0; yi_q <= '0; si_q <= '0;
			mask_q <= '0; gw_q <= '0; type_q <= '0; maskf_q <= 1'b0; gwf_q <= 1'b0;
		end else if (acc && is_byte) begin
			if (is_end) begin
				off_q <= '0; oph_q <= OPH_CODE; ocode_q <= '0; oleft_q <= '0;
				oidx_q <= '0; done_q <= 1'b0; mism_q <= 1'b0; yi_q <= '0; si_q <= '0;
				mask_q <= '0; gw_q <= '0; type_q <= '0; maskf_q <= 1'b0; gwf_q <= 1'b0;
			end else begin
				off_q <= off_n; oph_q <= oph_n; ocode_q <= ocode_n; oleft_q <= oleft_n;
				oidx_q <= oidx_n; done_q <= done_n; mism_q <= mism_n; yi_q <= yi_n;
				si_q <= si_n; mask_q <= mask_n; gw_q <= gw_n; type_q <= type_n;
				maskf_q <= maskf_n; gwf_q <= gwf_n;
			end
		end
	end

	always_comb begin
		cmd_valid = in_ch.valid && !xid_hold &&
			(it.mode == MODE_START || it.mode == MODE_TICK || is_end);
		cmd.mode = it.mode;
		cmd.new_xid = it.new_xid;
		cmd.type_ok = type_n[8] && !mism_n && (off_n >= 11'd8);
		cmd.rtype = type_n[7:0];
		cmd.yiaddr = yi_n;
		cmd.siaddr = si_n;
		cmd.mask = mask_n;
		cmd.mask_found = maskf_n;
		cmd.gateway = gw_n;
		cmd.gateway_found = gwf_n;
	end

`ifndef SYNTH
	a_off_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && is_byte && !is_end && off_q == OffMax) |=> off_q == OffMax)
		else $error("offset left saturation");
	a_end_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && is_end) |=> (off_q == '0 && !type_q[8] && !mism_q))
		else $error("parser not cleared after reply");
	a_no_cmd_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && is_byte && !it.last_byte) |-> !cmd_valid)
		else $error("command for mid-reply byte");
`endif
endmodule

// ----- rtl/dcs_queue.sv -----
// ----------------------------------------------------------------------------
// dcs_queue: two-entry command queue
// Decouples the parser front from the sequencer back.
// ----------------------------------------------------------------------------
module dcs_queue import dcs_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  cmd_t in_cmd,
	output logic in_ready,
	output logic out_valid,
	output cmd_t out_cmd,
	input  logic out_ready
);
	cmd_t mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic push, pop;

	assign in_ready = cnt_q != 2'd2;
	assign out_valid = cnt_q != 2'd0;
	assign out_cmd = mem_q[rp_q];
	assign push = in_valid && in_ready;
	assign pop = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= in_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

`ifndef SYNTH
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n) cnt_q != 2'd3)
		else $error("queue count overflow");
	a_ptr: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd0 || cnt_q == 2'd2) |-> wp_q == rp_q)
		else $error("queue pointers inconsistent");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready && !push) |=> $stable(cnt_q))
		else $error("queue count moved without handshake");
`endif
endmodule

// ----- rtl/dcs_sequencer.sv -----
// ----------------------------------------------------------------------------
// dcs_sequencer: back end
// Runs the discover/request/ack phases, timeouts and retries.
// ----------------------------------------------------------------------------
module dcs_sequencer import dcs_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cmd_valid,
	input  cmd_t         cmd,
	output logic         cmd_ready,
	input  logic [15:0]  timeout_ticks,
	input  logic [3:0]   max_attempts,
	output logic [31:0]  cur_xid,
	dcs_result_if.source out_ch
);
	logic [1:0]  phase_q;
	logic [31:0] xid_q, offsrv_q;
	logic [3:0]  att_q;
	logic [15:0] tick_q;
	logic        ov_q;
	result_t     res_q;

	logic take, emit;
	result_t r;
	logic [1:0]  phase_n;
	logic [31:0] xid_n, offsrv_n;
	logic [3:0]  att_n;
	logic [15:0] tick_n;

	assign cur_xid = xid_q;
	assign cmd_ready = !ov_q || out_ch.ready;
	assign take = cmd_valid && cmd_ready;
	assign out_ch.valid = ov_q;
	assign out_ch.data = res_q;

	always_comb begin
		phase_n = phase_q; xid_n = xid_q; offsrv_n = offsrv_q;
		att_n = att_q; tick_n = tick_q;
		r = '0;
		emit = 1'b0;
		case (cmd.mode)
			MODE_START: begin
				att_n = 4'd0; xid_n = cmd.new_xid; phase_n = PH_WOFFER; tick_n = '0;
				emit = 1'b1; r.action = ACT_DISCOVER; r.xid = cmd.new_xid;
			end
			MODE_TICK: begin
				if (phase_q != PH_IDLE) begin
					tick_n = tick_q + 16'd1;
					if (tick_n >= timeout_ticks) begin
						att_n = att_q + 4'd1;
						emit = 1'b1;
						r.attempt = att_n;
						if (att_n >= max_attempts) begin
							phase_n = PH_IDLE; tick_n = '0;
							r.action = ACT_FAILURE; r.xid = xid_q;
						end else begin
							xid_n = cmd.new_xid; phase_n = PH_WOFFER; tick_n = '0;
							r.action = ACT_DISCOVER; r.xid = cmd.new_xid;
						end
					end
				end
			end
			MODE_BYTE: begin
				emit = 1'b1;
				r.action = ACT_IGNORED;
				if (cmd.type_ok && cmd.rtype == MSG_OFFER && phase_q == PH_WOFFER) begin
					offsrv_n = cmd.siaddr;
					phase_n = PH_WACK; tick_n = '0;
					r.action = ACT_REQUEST; r.xid = xid_q; r.attempt = att_q;
					r.srv_addr = cmd.siaddr; r.cli_addr = cmd.yiaddr;
				end else if (cmd.type_ok && cmd.rtype == MSG_ACK && phase_q == PH_WACK) begin
					phase_n = PH_IDLE; tick_n = '0;
					r.action = ACT_SUCCESS; r.xid = xid_q; r.attempt = att_q;
					r.srv_addr = offsrv_q; r.cli_addr = cmd.yiaddr;
					r.subnet = cmd.mask; r.mask_found = cmd.mask_found;
					r.router_addr = cmd.gateway; r.gateway_found = cmd.gateway_found;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE; xid_q <= '0; offsrv_q <= '0;
			att_q <= '0; tick_q <= '0; ov_q <= 1'b0;
		end else begin
			if (take) begin
				phase_q <= phase_n; xid_q <= xid_n;
				offsrv_q <= offsrv_n; att_q <= att_n; tick_q <= tick_n;
			end
			if (take && emit) ov_q <= 1'b1;
			else if (out_ch.ready) ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && emit) res_q <= r;
	end

`ifndef SYNTH
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && !out_ch.ready) |=> (ov_q && $stable(res_q)))
		else $error("result lost under stall");
	a_idle_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(take && cmd.mode == MODE_TICK && phase_q == PH_IDLE) |=> $stable(att_q))
		else $error("idle tick changed attempts");
	a_phase: assert property (@(posedge clk) disable iff (!arst_n) phase_q != 2'd3)
		else $error("bad phase");
`endif
endmodule

// ----- rtl/dhcp_client_sequencer.sv -----
// ----------------------------------------------------------------------------
// dhcp_client_sequencer: DHCP client sequencer top level
// Parser front, command queue, sequencer back, APB register port.
// ----------------------------------------------------------------------------
//  channel | dir | handshake      | payload
//  in_ch   | in  | valid/ready    | mode, data_byte, last_byte, new_xid
//  out_ch  | out | valid/ready    | action .. gateway_found
//  apb     | in  | psel/penable   | timeout_ticks (0x0), max_attempts (0x4)
//
// One item per cycle while the queue has room and no xid byte waits;
// a start, tick or reply end enters the two-entry queue when accepted;
// the sequencer takes it and offers any result from its output register.
// Reset clears all but queue and result data, loads the register defaults.
// A stalled result stalls the sequencer; the queue absorbs two more commands.
// An xid byte of a reply waits until the queue is empty.
module dhcp_client_sequencer import dcs_pkg::*; #(
	parameter int unsigned OPTION_BYTES = OptionBytesDefault
) (
	input  logic         clk,
	input  logic         arst_n,
	dcs_item_if.sink     in_ch,
	dcs_result_if.source out_ch,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);
	logic [15:0] timeout_q;
	logic [3:0]  attempts_q;
	logic [31:0] cur_xid;
	logic pv, pr, qv, qr;
	cmd_t pc, qc;

	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET; attempts_q <= ATTEMPTS_RESET;
		end else if (psel && penable && pwrite && paddr[1:0] == 2'd0) begin
			case (paddr[2])
				REG_TIMEOUT:  timeout_q <= pwdata[15:0];
				REG_ATTEMPTS: attempts_q <= pwdata[3:0];
				default: ;
			endcase
		end
	end
	always_comb begin
		case (paddr[2])
			REG_TIMEOUT:  prdata = {16'd0, timeout_q};
			REG_ATTEMPTS: prdata = {28'd0, attempts_q};
			default:      prdata = '0;
		endcase
	end

	dcs_parser #(.OPTION_BYTES(OPTION_BYTES)) u_parser (
		.clk, .arst_n, .in_ch, .cur_xid, .q_busy(qv),
		.cmd_valid(pv), .cmd(pc), .cmd_ready(pr));

	dcs_queue u_queue (
		.clk, .arst_n, .in_valid(pv), .in_cmd(pc), .in_ready(pr),
		.out_valid(qv), .out_cmd(qc), .out_ready(qr));

	dcs_sequencer u_seq (
		.clk, .arst_n, .cmd_valid(qv), .cmd(qc), .cmd_ready(qr),
		.timeout_ticks(timeout_q), .max_attempts(attempts_q), .cur_xid, .out_ch);
endmodule

// ----- test/tb_dhcp_client_sequencer.sv -----
// ----------------------------------------------------------------------------
// tb_dhcp_client_sequencer: self-checking bench for the DHCP client sequencer
// Drives starts, ticks and reply packets (offers, ACKs, broken and foreign
// replies), predicts each result in a scoreboard and checks it field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_dhcp_client_sequencer;
	import dcs_pkg::*;

	localparam int unsigned OptLimit = 236 + OptionBytesDefault;
	localparam int unsigned CycleLimit = 3000000;

	class lease_scoreboard;
		logic [15:0] timeout_ticks;
		logic [3:0]  max_attempts;
		logic [1:0]  phase;
		logic [31:0] cur_xid;
		logic [3:0]  attempts;
		logic [15:0] ticks;
		logic [31:0] offered_ip, offer_server;
		logic [10:0] offset;
		logic [1:0]  oph;
		logic [7:0]  ocode, oleft, oidx;
		logic        odone, xid_bad;
		logic [31:0] yiaddr, siaddr, mask, gw;
		logic [7:0]  rtype;
		logic        type_seen, mask_seen, gw_seen;
		result_t     pending[$];
		int          errors;
		int          checked;

		function new();
			timeout_ticks = TIMEOUT_RESET;
			max_attempts = ATTEMPTS_RESET;
			phase = PH_IDLE;
			cur_xid = 0;
			attempts = 0;
			ticks = 0;
			offered_ip = 0;
			offer_server = 0;
			errors = 0;
			checked = 0;
			clear_parser();
		endfunction

		function void clear_parser();
			offset = 0; oph = OPH_CODE; ocode = 0; oleft = 0; oidx = 0;
			odone = 0; xid_bad = 0; yiaddr = 0; siaddr = 0; mask = 0; gw = 0;
			rtype = 0; type_seen = 0; mask_seen = 0; gw_seen = 0;
		endfunction

		function void option_byte(logic [7:0] b);
			logic full;
			if (oph == OPH_CODE) begin
				if (b == OPT_END) odone = 1;
				else if (b != OPT_PAD) begin
					ocode = b;
					oph = OPH_LEN;
				end
			end else if (oph == OPH_LEN) begin
				oleft = b;
				oidx = 0;
				oph = (b == 0) ? OPH_CODE : OPH_DATA;
			end else begin
				full = (int'(oidx) + int'(oleft)) >= 4 && oidx < 4;
				if (ocode == OPT_MSGTYPE && oidx == 0 && !type_seen) begin
					rtype = b;
					type_seen = 1;
				end
				if (ocode == OPT_MASK && full && !mask_seen) begin
					mask[(3 - oidx[1:0]) * 8 +: 8] = b;
					if (oidx == 3) mask_seen = 1;
				end
				if (ocode == OPT_ROUTER && full && !gw_seen) begin
					gw[(3 - oidx[1:0]) * 8 +: 8] = b;
					if (oidx == 3) gw_seen = 1;
				end
				oidx = oidx + 1;
				oleft = oleft - 1;
				if (oleft == 0) oph = OPH_CODE;
			end
		endfunction

		function void parse_byte(logic [7:0] b);
			if (offset >= 4 && offset < 8) begin
				if (cur_xid[(7 - offset) * 8 +: 8] != b) xid_bad = 1;
			end else if (offset >= 16 && offset < 20) begin
				yiaddr[(19 - offset) * 8 +: 8] = b;
			end else if (offset >= 20 && offset < 24) begin
				siaddr[(23 - offset) * 8 +: 8] = b;
			end else if (offset >= 240 && offset < OptLimit && !odone) begin
				option_byte(b);
			end
			if (offset != OffMax) offset = offset + 1;
		endfunction

		function void discover(logic [31:0] x);
			result_t r;
			r = '0;
			cur_xid = x;
			phase = PH_WOFFER;
			ticks = 0;
			r.action = ACT_DISCOVER;
			r.xid = x;
			r.attempt = attempts;
			pending.push_back(r);
		endfunction

		function void note_item(item_t it);
			result_t r;
			logic ok;
			r = '0;
			case (it.mode)
				MODE_START: begin
					attempts = 0;
					discover(it.new_xid);
				end
				MODE_TICK: begin
					if (phase != PH_IDLE) begin
						ticks = ticks + 1;
						if (ticks >= timeout_ticks) begin
							attempts = attempts + 1;
							if (attempts >= max_attempts) begin
								phase = PH_IDLE;
								ticks = 0;
								r.action = ACT_FAILURE;
								r.xid = cur_xid;
								r.attempt = attempts;
								pending.push_back(r);
							end else discover(it.new_xid);
						end
					end
				end
				MODE_BYTE: begin
					parse_byte(it.data_byte);
					if (it.last_byte) begin
						ok = type_seen && !xid_bad && offset >= 8;
						r.action = ACT_IGNORED;
						if (ok && rtype == MSG_OFFER && phase == PH_WOFFER) begin
							offered_ip = yiaddr;
							offer_server = siaddr;
							phase = PH_WACK;
							ticks = 0;
							r.action = ACT_REQUEST;
							r.xid = cur_xid;
							r.attempt = attempts;
							r.srv_addr = offer_server;
							r.cli_addr = offered_ip;
						end else if (ok && rtype == MSG_ACK && phase == PH_WACK) begin
							phase = PH_IDLE;
							ticks = 0;
							r.action = ACT_SUCCESS;
							r.xid = cur_xid;
							r.attempt = attempts;
							r.srv_addr = offer_server;
							r.cli_addr = yiaddr;
							r.subnet = mask;
							r.mask_found = mask_seen;
							r.router_addr = gw;
							r.gateway_found = gw_seen;
						end
						pending.push_back(r);
						clear_parser();
					end
				end
				default: ;
			endcase
		endfunction

		task report(string what, logic [31:0] got, logic [31:0] want);
			$display("mismatch %s: got %h, expected %h", what, got, want);
			errors++;
		endtask

		task check_result(result_t got);
			result_t want;
			checked++;
			if (pending.size() == 0) begin
				report("unexpected word", 32'(got.action), 32'd0);
				return;
			end
			want = pending.pop_front();
			if (got.action !== want.action)
				report("action", 32'(got.action), 32'(want.action));
			if (got.xid !== want.xid) report("xid", got.xid, want.xid);
			if (got.attempt !== want.attempt)
				report("attempt", 32'(got.attempt), 32'(want.attempt));
			if (got.srv_addr !== want.srv_addr)
				report("srv_addr", got.srv_addr, want.srv_addr);
			if (got.cli_addr !== want.cli_addr)
				report("cli_addr", got.cli_addr, want.cli_addr);
			if (got.subnet !== want.subnet) report("subnet", got.subnet, want.subnet);
			if (got.mask_found !== want.mask_found)
				report("mask_found", 32'(got.mask_found), 32'(want.mask_found));
			if (got.router_addr !== want.router_addr)
				report("router_addr", got.router_addr, want.router_addr);
			if (got.gateway_found !== want.gateway_found)
				report("gateway_found", 32'(got.gateway_found), 32'(want.gateway_found));
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	int          src_idle, snk_idle;
	int          hold_cycles;
	int          cycles;
	int          n_items;
	int          n_packets;
	lease_scoreboard sb;

	dcs_item_if   in_ch ();
	dcs_result_if out_ch ();

	dhcp_client_sequencer dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CycleLimit) begin
				$display("timeout after %0d cycles", cycles);
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	// receiver: random stalls, long hold-offs on request
	initial begin
		out_ch.ready = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				hold_cycles--;
				out_ch.ready <= 0;
			end else begin
				out_ch.ready <= ($urandom_range(99) >= snk_idle);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);
	end

	task automatic send(item_t it);
		in_ch.data <= it;
		in_ch.valid <= 1;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		sb.note_item(it);
		n_items++;
		if (src_idle > 0 && $urandom_range(99) < src_idle) begin
			in_ch.valid <= 0;
			@(posedge clk);
			while ($urandom_range(99) < src_idle) @(posedge clk);
		end
	endtask

	task automatic rest();
		in_ch.valid <= 0;
		@(posedge clk);
	endtask

	task automatic wait_drained();
		rest();
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(logic [0:0] idx, logic [31:0] val);
		psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		if (idx == REG_TIMEOUT) sb.timeout_ticks = val[15:0];
		else sb.max_attempts = val[3:0];
	endtask

	function automatic item_t mk(logic [1:0] m, logic [7:0] b, logic l, logic [31:0] x);
		item_t it;
		it.mode = m; it.data_byte = b; it.last_byte = l; it.new_xid = x;
		return it;
	endfunction

	task automatic start(logic [31:0] x);
		send(mk(MODE_START, 8'($urandom), 1'($urandom), x));
	endtask

	task automatic tick();
		send(mk(MODE_TICK, 8'($urandom), 1'($urandom), $urandom));
	endtask

	// send a reply byte list; the final byte carries last_byte
	task automatic send_packet(logic [7:0] pkt[$]);
		foreach (pkt[i]) send(mk(MODE_BYTE, pkt[i], i == pkt.size() - 1, $urandom));
		n_packets++;
	endtask

	// build a reply: random header with the xid, option list; variety from flags
	function automatic void build_reply(ref logic [7:0] pkt[$], input logic [7:0] mtype,
			input logic [31:0] xid, input bit want_type, input bit noisy);
		logic [31:0] w;
		int n;
		pkt = {};
		for (int i = 0; i < 240; i++) pkt.push_back(8'($urandom));
		for (int i = 0; i < 4; i++) pkt[4 + i] = xid[(3 - i) * 8 +: 8];
		if (noisy && $urandom_range(3) == 0) pkt[4 + $urandom_range(3)] ^= 8'h01 << $urandom_range(7);
		n = $urandom_range(2);
		repeat (n) pkt.push_back(OPT_PAD);
		if (noisy && $urandom_range(1)) begin
			pkt.push_back(OPT_MASK); pkt.push_back(8'd2);
			pkt.push_back(8'($urandom)); pkt.push_back(8'($urandom));
		end
		if ($urandom_range(3) == 0) begin
			pkt.push_back(8'd12); n = $urandom_range(6); pkt.push_back(8'(n));
			repeat (n) pkt.push_back(8'($urandom));
		end
		if (want_type) begin
			pkt.push_back(OPT_MSGTYPE); pkt.push_back(8'd1); pkt.push_back(mtype);
		end
		if ($urandom_range(1)) begin
			w = $urandom; n = 4 + ($urandom_range(3) == 0 ? 4 : 0);
			pkt.push_back(OPT_MASK); pkt.push_back(8'(n));
			for (int i = 0; i < n; i++) pkt.push_back(i < 4 ? w[(3 - i) * 8 +: 8] : 8'($urandom));
		end
		if ($urandom_range(1)) begin
			n = $urandom_range(1) ? 4 : 8;
			pkt.push_back(OPT_ROUTER); pkt.push_back(8'(n));
			for (int i = 0; i < n; i++) pkt.push_back(8'($urandom));
		end
		if (want_type && $urandom_range(3) == 0) begin
			pkt.push_back(OPT_MSGTYPE); pkt.push_back(8'd1); pkt.push_back(8'($urandom));
		end
		if ($urandom_range(3) != 0) pkt.push_back(OPT_END);
		n = $urandom_range(3);
		repeat (n) pkt.push_back(8'($urandom));
	endfunction

	task automatic exchange();
		logic [7:0] pkt[$];
		int r;
		start($urandom);
		r = $urandom_range(9);
		if (r == 0) begin
			build_reply(pkt, 8'($urandom), $urandom, 1'($urandom_range(1)), 1'b1);
			send_packet(pkt);
		end
		if ($urandom_range(4) == 0) repeat ($urandom_range(3)) tick();
		build_reply(pkt, MSG_OFFER, sb.cur_xid, $urandom_range(9) != 0, $urandom_range(5) == 0);
		send_packet(pkt);
		if ($urandom_range(4) == 0) repeat ($urandom_range(3)) tick();
		build_reply(pkt, $urandom_range(7) == 0 ? MSG_OFFER : MSG_ACK, sb.cur_xid,
			1'b1, $urandom_range(5) == 0);
		send_packet(pkt);
	endtask

	task automatic noise();
		logic [7:0] pkt[$];
		int n;
		case ($urandom_range(4))
			0: repeat ($urandom_range(5)) tick();
			1: send(mk(MODE_NONE, 8'($urandom), 1'($urandom), $urandom));
			2: begin
				n = 1 + $urandom_range(10);
				pkt = {};
				repeat (n) pkt.push_back(8'($urandom));
				send_packet(pkt);
			end
			3: begin
				pkt = {};
				repeat (600) pkt.push_back(8'($urandom));
				send_packet(pkt);
			end
			default: start($urandom);
		endcase
	endtask

	initial begin
		int phase_no;
		int phase_base;
		sb = new();
		n_items = 0;
		n_packets = 0;
		hold_cycles = 0;
		src_idle = 0;
		snk_idle = 0;
		arst_n = 0;
		psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
		in_ch.valid = 0;
		in_ch.data = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: defaults, extreme fields, discover, ignored and failure actions
		send(mk(MODE_TICK, 8'hff, 1, 32'hffffffff));
		send(mk(MODE_NONE, 8'h00, 1, 32'h0));
		send(mk(MODE_BYTE, 8'hff, 1, 32'hffffffff));
		start(32'hffffffff);
		start(32'h0);
		send(mk(MODE_BYTE, 8'h00, 1, 32'h0));
		wait_drained();
		write_reg(REG_TIMEOUT, 32'd0);
		write_reg(REG_ATTEMPTS, 32'd0);
		start(32'h12345678);
		tick();
		tick();
		wait_drained();
		write_reg(REG_TIMEOUT, 32'd2);
		write_reg(REG_ATTEMPTS, 32'd15);
		start($urandom);
		repeat (34) tick();
		wait_drained();

		// random: three idling phases, register settings vary between them
		for (phase_no = 0; phase_no < 3; phase_no++) begin
			src_idle = (phase_no == 0) ? 29 : (phase_no == 1) ? 53 : 0;
			snk_idle = (phase_no == 0) ? 53 : (phase_no == 1) ? 29 : 0;
			case (phase_no)
				0: begin write_reg(REG_TIMEOUT, 32'd3); write_reg(REG_ATTEMPTS, 32'd2); end
				1: begin write_reg(REG_TIMEOUT, 32'd65535); write_reg(REG_ATTEMPTS, 32'd1); end
				default: begin write_reg(REG_TIMEOUT, 32'd1); write_reg(REG_ATTEMPTS, 32'd4); end
			endcase
			hold_cycles = 300;
			repeat (6) tick();
			start($urandom);
			phase_base = n_items;
			do begin
				if ($urandom_range(3) != 0) exchange();
				else noise();
				if ($urandom_range(30) == 0) wait_drained();
			end while (n_items < phase_base + 500);
			wait_drained();
		end
		if (sb.pending.size() != 0)
			sb.report("results never seen", 32'(sb.pending.size()), 32'd0);
		$display("%0d items, %0d packets, %0d results checked over three idling phases",
			n_items, n_packets, sb.checked);
		if (sb.errors == 0) $display("Testbench completed without errors");
		else $display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/dcs_pkg.sv
rtl/dcs_item_if.sv
rtl/dcs_result_if.sv
rtl/dcs_parser.sv
rtl/dcs_queue.sv
rtl/dcs_sequencer.sv
rtl/dhcp_client_sequencer.sv
test/tb_dhcp_client_sequencer.sv
